// File: sv/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg: shared types and constants for the directory entry search
// Register indexes, result status codes, entry layout positions and the
// structs passed between the configuration, scan and output stages.
// ----------------------------------------------------------------------------
package fdes_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_NAME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_EXT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_MASK  = 2'd2;

    // Reset values: all spaces, skip volume label / system / hidden / read-only
    localparam logic [63:0] MATCH_NAME_RST = 64'h2020_2020_2020_2020;
    localparam logic [23:0] TARGET_EXT_RST = 24'h20_2020;
    localparam logic [7:0]  SKIP_MASK_RST  = 8'h0F;

    // Marker bytes in the first position of an entry
    localparam logic [7:0] END_MARK     = 8'h00;
    localparam logic [7:0] DELETED_MARK = 8'hE5;

    // Byte positions inside a 32-byte entry
    localparam logic [4:0] POS_FIRST     = 5'd0;
    localparam logic [4:0] POS_EXT_FIRST = 5'd8;
    localparam logic [4:0] POS_ATTR      = 5'd11;
    localparam logic [4:0] POS_CL_HI_LO  = 5'd20;
    localparam logic [4:0] POS_CL_HI_HI  = 5'd21;
    localparam logic [4:0] POS_CL_LO_LO  = 5'd26;
    localparam logic [4:0] POS_CL_LO_HI  = 5'd27;
    localparam logic [4:0] POS_SIZE      = 5'd28;
    localparam logic [4:0] POS_LAST      = 5'd31;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_END_MARK  = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    // Live configuration
    typedef struct packed {
        logic [63:0] match_name;
        logic [23:0] target_ext;
        logic [7:0]  skip_attr_mask;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [31:0] entry_size;
        logic [31:0] start_cluster;
        status_t     status;
    } result_t;

endpackage

// File: sv/fdes_cfg.sv
// ----------------------------------------------------------------------------
// fdes_cfg: configuration registers
// Holds the space padded target name and extension and the attribute skip
// mask. Writes are taken every cycle; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fdes_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fdes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                     cfg_data,
    output fdes_pkg::cfg_t                  cfg
);
    import fdes_pkg::*;

    logic [63:0] match_name_reg;
    logic [23:0] target_ext_reg;
    logic [7:0]  skip_attr_mask_reg;

    assign cfg_ready = 1'b1;

    // Register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_name_reg     <= MATCH_NAME_RST;
            target_ext_reg     <= TARGET_EXT_RST;
            skip_attr_mask_reg <= SKIP_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MATCH_NAME: match_name_reg     <= cfg_data;
                CFG_TARGET_EXT: target_ext_reg     <= cfg_data[23:0];
                CFG_SKIP_MASK:  skip_attr_mask_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg.match_name     = match_name_reg;
    assign cfg.target_ext     = target_ext_reg;
    assign cfg.skip_attr_mask = skip_attr_mask_reg;

endmodule

// File: sv/fdes_scan.sv
// ----------------------------------------------------------------------------
// fdes_scan: per-byte entry scanner
// Tracks the position within the current 32-byte entry, compares the name
// and extension bytes, checks the skip conditions and captures the cluster
// and size fields. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module fdes_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  fdes_pkg::cfg_t    cfg,
    input  logic              beat,        // byte transaction this cycle
    input  logic [7:0]        entry_byte,
    input  logic              first_of_dir,
    input  logic              last_of_dir,
    output logic              res_push,
    output fdes_pkg::result_t res
);
    import fdes_pkg::*;

    logic [4:0]  byte_index_reg,  byte_index_next;
    logic        name_equal_reg,  name_equal_next;
    logic        skipped_reg,     skipped_next;
    logic [15:0] cl_hi_reg,       cl_hi_next;
    logic [15:0] cl_lo_reg,       cl_lo_next;
    logic [31:0] size_reg,        size_next;
    logic        done_reg,        done_next;

    // Next state and result for one byte
    always_comb
    begin
        logic [4:0]  idx;
        logic        eq;
        logic        skp;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [31:0] sz;
        logic        dn;
        logic [7:0]  ext_byte;
        logic        found;

        byte_index_next = byte_index_reg;
        name_equal_next = name_equal_reg;
        skipped_next    = skipped_reg;
        cl_hi_next      = cl_hi_reg;
        cl_lo_next      = cl_lo_reg;
        size_next       = size_reg;
        done_next       = done_reg;
        res_push        = 1'b0;
        res             = '0;

        // first_of_dir restarts at position zero of a fresh entry
        idx   = first_of_dir ? 5'd0  : byte_index_reg;
        eq    = first_of_dir ? 1'b1  : name_equal_reg;
        skp   = first_of_dir ? 1'b0  : skipped_reg;
        hi    = first_of_dir ? 16'd0 : cl_hi_reg;
        lo    = first_of_dir ? 16'd0 : cl_lo_reg;
        sz    = first_of_dir ? 32'd0 : size_reg;
        dn    = first_of_dir ? 1'b0  : done_reg;
        found = 1'b0;

        // extension byte for positions 8..10
        unique case (idx[1:0])
            2'd0:    ext_byte = cfg.target_ext[7:0];
            2'd1:    ext_byte = cfg.target_ext[15:8];
            2'd2:    ext_byte = cfg.target_ext[23:16];
            default: ext_byte = 8'h00;
        endcase

        if (beat)
        begin
            byte_index_next = idx;
            name_equal_next = eq;
            skipped_next    = skp;
            cl_hi_next      = hi;
            cl_lo_next      = lo;
            size_next       = sz;
            done_next       = dn;

            if (!dn)
            begin
                if (idx == POS_FIRST && entry_byte == END_MARK)
                begin
                    // end of directory marker
                    done_next    = 1'b1;
                    res_push     = 1'b1;
                    res.status   = ST_END_MARK;
                end
                else
                begin
                    if (idx == POS_FIRST && entry_byte == DELETED_MARK)
                        skp = 1'b1;

                    // field handling by position
                    priority if (idx < POS_EXT_FIRST)
                    begin
                        if (cfg.match_name[{idx[2:0], 3'b000} +: 8] != entry_byte)
                            eq = 1'b0;
                    end
                    else if (idx < POS_ATTR)
                    begin
                        if (ext_byte != entry_byte)
                            eq = 1'b0;
                    end
                    else if (idx == POS_ATTR)
                    begin
                        if ((entry_byte & cfg.skip_attr_mask) != 8'h00)
                            skp = 1'b1;
                    end
                    else if (idx == POS_CL_HI_LO)
                        hi[7:0] = entry_byte;
                    else if (idx == POS_CL_HI_HI)
                        hi[15:8] = entry_byte;
                    else if (idx == POS_CL_LO_LO)
                        lo[7:0] = entry_byte;
                    else if (idx == POS_CL_LO_HI)
                        lo[15:8] = entry_byte;
                    else if (idx >= POS_SIZE)
                        sz[{idx[1:0], 3'b000} +: 8] = entry_byte;
                    else
                    begin
                    end

                    // entry completion
                    if (idx == POS_LAST)
                    begin
                        if (eq && !skp)
                        begin
                            found             = 1'b1;
                            done_next         = 1'b1;
                            res_push          = 1'b1;
                            res.status        = ST_FOUND;
                            res.start_cluster = {hi, lo};
                            res.entry_size    = sz;
                        end
                        byte_index_next = 5'd0;
                        name_equal_next = 1'b1;
                        skipped_next    = 1'b0;
                        cl_hi_next      = 16'd0;
                        cl_lo_next      = 16'd0;
                        size_next       = 32'd0;
                    end
                    else
                    begin
                        byte_index_next = idx + 5'd1;
                        name_equal_next = eq;
                        skipped_next    = skp;
                        cl_hi_next      = hi;
                        cl_lo_next      = lo;
                        size_next       = sz;
                    end

                    // directory ran out without a match
                    if (last_of_dir && !found)
                    begin
                        done_next  = 1'b1;
                        res_push   = 1'b1;
                        res.status = ST_EXHAUSTED;
                    end
                end
            end
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 5'd0;
            name_equal_reg <= 1'b1;
            skipped_reg    <= 1'b0;
            cl_hi_reg      <= 16'd0;
            cl_lo_reg      <= 16'd0;
            size_reg       <= 32'd0;
            done_reg       <= 1'b1;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            name_equal_reg <= name_equal_next;
            skipped_reg    <= skipped_next;
            cl_hi_reg      <= cl_hi_next;
            cl_lo_reg      <= cl_lo_next;
            size_reg       <= size_next;
            done_reg       <= done_next;
        end
    end

endmodule

// File: sv/fdes_out.sv
// ----------------------------------------------------------------------------
// fdes_out: result register with skid stage
// Output register toward the stream master side plus one skid entry, so a
// byte can still be taken while a finished result waits.
// ----------------------------------------------------------------------------
module fdes_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fdes_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output fdes_pkg::result_t m_data
);
    import fdes_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop     = out_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= push_data;
            end
            else
                out_data_reg <= push_data;
        end
        else if (push)
            skid_data_reg <= push_data;
    end

endmodule

// File: sv/fat_directory_entry_search.sv
// A result goes to the output register, or to the skid entry while an earlier one waits.
// Throughput: one directory byte per cycle while the skid entry is free; the per-byte
// compare and field capture path sets this, and a two-entry result stage keeps input
// open while a result waits. Reset: target name and extension are all spaces, skip
// mask is 0x0F, and the search is idle until a byte marked with first_of_dir arrives.
// ----------------------------------------------------------------------------
// fat_directory_entry_search: short-name search over a streamed directory
// Scans 32-byte directory entries byte by byte and reports the first
// cluster and size of the matching entry, or why the search ended.
// ----------------------------------------------------------------------------
module fat_directory_entry_search (
    input  logic                             clk,
    input  logic                             rst_n,
    // byte stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] entry_byte
    input  logic                             s_tuser,   // [0] first_of_dir
    input  logic                             s_tlast,   // last_of_dir
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // [31:0] start_cluster, [63:32] entry_size
    output logic [1:0]                       m_tuser,   // [1:0] status
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);
    import fdes_pkg::*;

    cfg_t    cfg;
    logic    beat;
    logic    res_push;
    result_t res;
    logic    space;
    result_t m_res;

    assign s_tready = space;
    assign beat     = s_tvalid && s_tready;

    fdes_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdes_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .beat         (beat),
        .entry_byte   (s_tdata),
        .first_of_dir (s_tuser),
        .last_of_dir  (s_tlast),
        .res_push     (res_push),
        .res          (res)
    );

    fdes_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_res)
    );

    assign m_tdata = {m_res.entry_size, m_res.start_cluster};
    assign m_tuser = m_res.status;

endmodule

// File: sv/fdes_checker.sv
// ----------------------------------------------------------------------------
// fdes_checker: port level checks for the directory entry search
// Watches the result stream for handshake and encoding problems.
// ----------------------------------------------------------------------------
module fdes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_ready
);
    import fdes_pkg::*;

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_FOUND || m_tuser == ST_END_MARK ||
                      m_tuser == ST_EXHAUSTED))
        else $error("undefined status code");

    // Not-found results carry zero cluster and size
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_FOUND |-> m_tdata == 64'd0)
        else $error("nonzero payload on a not-found result");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind fat_directory_entry_search fdes_checker u_fdes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
